### src/upsc_pkg.sv
package upsc_pkg;

  // Field and register widths.
  localparam int SCALE_W    = 7;
  localparam int DIM_W      = 13;
  localparam int ROW_W      = 12;
  localparam int PAD_W      = 2;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Limits and defaults.
  localparam int SCALE_MAX      = 100;
  localparam int HEIGHT_MAX     = 4096;
  localparam int ROW_PIXELS_DEF = 4096;
  localparam int QDEPTH         = 4;

  localparam logic [CHAN_W-1:0] PAD_BYTE = 8'h00;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  // Request kinds.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PIXEL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PAD       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd4;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                row_end;
    logic                frame_end;
    logic                use_pixel;
  } desc_t;

  // One finished result as held in the output queue.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PIX_W-1:0]    pixel;
    logic                row_end;
    logic                frame_end;
  } result_t;

endpackage

### src/upsc_ram.sv
module upsc_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/upsc_front.sv
module upsc_front #(
  parameter int MAX_ROW_PIXELS = upsc_pkg::ROW_PIXELS_DEF,
  parameter int ADDR_W         = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [upsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [upsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [upsc_pkg::CHAN_W-1:0]      blue_in,
  input  logic [upsc_pkg::CHAN_W-1:0]      green_in,
  input  logic [upsc_pkg::CHAN_W-1:0]      red_in,
  input  logic                             space,
  output upsc_pkg::desc_t                  desc,
  output logic                             ram_we,
  output logic [ADDR_W-1:0]                ram_waddr,
  output logic [upsc_pkg::PIX_W-1:0]       ram_wdata,
  output logic [ADDR_W-1:0]                ram_raddr
);

  import upsc_pkg::*;

  // Configuration registers.
  logic [SCALE_W-1:0] scale_factor;
  logic [DIM_W-1:0]   source_width;
  logic [DIM_W-1:0]   source_height;

  // Sequencing state.
  logic [DIM_W-1:0]   load_column, load_column_next;
  logic               row_ready, row_ready_next;
  logic [DIM_W-1:0]   emit_column, emit_column_next;
  logic [SCALE_W-1:0] across_copy, across_copy_next;
  logic [SCALE_W-1:0] down_copy, down_copy_next;
  logic [PAD_W-1:0]   pad_sent, pad_sent_next;
  logic [ROW_W-1:0]   source_row, source_row_next;

  // Effective (clamped) settings.
  logic [SCALE_W-1:0] eff_s;
  logic [DIM_W-1:0]   eff_w;
  logic [DIM_W-1:0]   eff_h;
  logic [PAD_W-1:0]   row_bytes_low;
  logic [PAD_W-1:0]   pad_count;

  logic               accept;
  logic               finish;
  logic [DIM_W-1:0]   wcol;
  logic [DIM_W:0]     lc_sum;
  logic [SCALE_W:0]   ac_sum;
  logic [DIM_W-1:0]   col_adv;
  logic [PAD_W:0]     ps_sum;
  logic [SCALE_W:0]   ds_sum;
  logic [ROW_W:0]     rs_sum;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= SCALE_W'(1);
      source_width  <= DIM_W'(1);
      source_height <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:  scale_factor  <= cfg_data[SCALE_W-1:0];
        REG_WIDTH:  source_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: source_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the settings into their legal ranges.
  always_comb begin
    if (scale_factor == '0) begin
      eff_s = SCALE_W'(1);
    end else if (32'(scale_factor) > SCALE_MAX) begin
      eff_s = SCALE_W'(SCALE_MAX);
    end else begin
      eff_s = scale_factor;
    end
    if (source_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (32'(source_width) > MAX_ROW_PIXELS) begin
      eff_w = DIM_W'(MAX_ROW_PIXELS);
    end else begin
      eff_w = source_width;
    end
    if (source_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (32'(source_height) > HEIGHT_MAX) begin
      eff_h = DIM_W'(HEIGHT_MAX);
    end else begin
      eff_h = source_height;
    end
  end

  // Pad bytes bring 3 * width * scale up to a multiple of four; only the
  // low two bits of each factor matter.
  always_comb begin
    row_bytes_low = PAD_W'(eff_w[PAD_W-1:0] * eff_s[PAD_W-1:0] * PAD_W'(3));
    pad_count     = PAD_W'(-row_bytes_low);
  end

  assign accept   = in_valid && space;
  assign in_ready = space;

  // A load column left beyond a narrowed width restarts at zero.
  assign wcol      = (load_column >= eff_w) ? '0 : load_column;
  assign ram_waddr = ADDR_W'(wcol);
  assign ram_wdata = {red_in, green_in, blue_in};
  assign ram_raddr = ADDR_W'(emit_column);

  // Classify the request and advance the counters.
  always_comb begin
    load_column_next = load_column;
    row_ready_next   = row_ready;
    emit_column_next = emit_column;
    across_copy_next = across_copy;
    down_copy_next   = down_copy;
    pad_sent_next    = pad_sent;
    source_row_next  = source_row;
    desc             = '0;
    ram_we           = 1'b0;
    finish           = 1'b0;
    lc_sum           = {1'b0, wcol} + 1'b1;
    ac_sum           = {1'b0, across_copy} + 1'b1;
    ps_sum           = {1'b0, pad_sent} + 1'b1;
    ds_sum           = {1'b0, down_copy} + 1'b1;
    rs_sum           = {1'b0, source_row} + 1'b1;
    col_adv          = emit_column;

    if (accept) begin
      desc.valid = 1'b1;
      if (req_type == REQ_PUSH) begin
        if (row_ready) begin
          desc.status = ST_BUSY;
        end else begin
          desc.status = ST_ACCEPTED;
          ram_we      = 1'b1;
          if (lc_sum >= {1'b0, eff_w}) begin
            load_column_next = '0;
            row_ready_next   = 1'b1;
          end else begin
            load_column_next = lc_sum[DIM_W-1:0];
          end
        end
      end else if (!row_ready) begin
        desc.status = ST_NOT_READY;
      end else if (emit_column < eff_w) begin
        desc.status    = ST_PIXEL;
        desc.use_pixel = 1'b1;
        if (ac_sum >= {1'b0, eff_s}) begin
          across_copy_next = '0;
          col_adv          = emit_column + 1'b1;
        end else begin
          across_copy_next = ac_sum[SCALE_W-1:0];
        end
        emit_column_next = col_adv;
        if (col_adv >= eff_w && pad_count == '0) begin
          finish = 1'b1;
        end
      end else begin
        desc.status   = ST_PAD;
        pad_sent_next = ps_sum[PAD_W-1:0];
        if (ps_sum >= {1'b0, pad_count}) begin
          finish = 1'b1;
        end
      end
    end

    // Close the output row; after the last replay release the buffer.
    if (finish) begin
      desc.row_end     = 1'b1;
      emit_column_next = '0;
      across_copy_next = '0;
      pad_sent_next    = '0;
      if (ds_sum >= {1'b0, eff_s}) begin
        down_copy_next = '0;
        row_ready_next = 1'b0;
        if (rs_sum >= eff_h) begin
          source_row_next = '0;
          desc.frame_end  = 1'b1;
        end else begin
          source_row_next = rs_sum[ROW_W-1:0];
        end
      end else begin
        down_copy_next = ds_sum[SCALE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_column <= '0;
      row_ready   <= 1'b0;
      emit_column <= '0;
      across_copy <= '0;
      down_copy   <= '0;
      pad_sent    <= '0;
      source_row  <= '0;
    end else begin
      load_column <= load_column_next;
      row_ready   <= row_ready_next;
      emit_column <= emit_column_next;
      across_copy <= across_copy_next;
      down_copy   <= down_copy_next;
      pad_sent    <= pad_sent_next;
      source_row  <= source_row_next;
    end
  end

  // Loading always restarts from column zero once a row is complete.
  a_load_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    row_ready |-> load_column == '0)
    else $error("load column moved while a row is held");

  // With no row held, the emit counters rest at zero.
  a_emit_idle_when_empty: assert property (@(posedge clk) disable iff (rst)
    !row_ready |-> (emit_column == '0 && across_copy == '0 && pad_sent == '0))
    else $error("emit counters active without a loaded row");

endmodule

### src/upsc_back.sv
module upsc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  upsc_pkg::desc_t              desc,
  input  logic [upsc_pkg::PIX_W-1:0]   ram_rdata,
  output logic                         space,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [upsc_pkg::STATUS_W-1:0] status,
  output logic [upsc_pkg::CHAN_W-1:0]  blue_out,
  output logic [upsc_pkg::CHAN_W-1:0]  green_out,
  output logic [upsc_pkg::CHAN_W-1:0]  red_out,
  output logic                         row_end,
  output logic                         frame_end
);

  import upsc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  // Stage that holds each request while the line buffer read data is registered.
  logic                stg_valid;
  logic [STATUS_W-1:0] stg_status;
  logic                stg_rend;
  logic                stg_fend;
  logic                stg_use_pixel;

  // Result queue.
  result_t             queue [QDEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                pop;
  result_t             entry;
  result_t             head;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= desc.valid;
    end
    stg_status    <= desc.status;
    stg_rend      <= desc.row_end;
    stg_fend      <= desc.frame_end;
    stg_use_pixel <= desc.use_pixel;
  end

  // Assemble the result; pad bytes and status-only results carry zero data.
  always_comb begin
    entry.status    = stg_status;
    entry.row_end   = stg_rend;
    entry.frame_end = stg_fend;
    if (stg_use_pixel) begin
      entry.pixel = ram_rdata;
    end else if (stg_status == ST_PAD) begin
      entry.pixel = {PAD_BYTE, PAD_BYTE, PAD_BYTE};
    end else begin
      entry.pixel = '0;
    end
  end

  // A request is taken only while the queue has room for it and for the
  // one already in the stage, so the stage never stalls.
  assign space = (32'(count) + 32'(stg_valid)) < QDEPTH;
  assign pop   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (stg_valid) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (stg_valid) begin
        wr_ptr <= PTR_W'((32'(wr_ptr) + 1) % QDEPTH);
      end
      if (pop) begin
        rd_ptr <= PTR_W'((32'(rd_ptr) + 1) % QDEPTH);
      end
      count <= CNT_W'(32'(count) + 32'(stg_valid) - 32'(pop));
    end
  end

  // The queue head drives the result ports.
  assign head      = queue[rd_ptr];
  assign out_valid = (count != '0);
  assign status    = head.status;
  assign red_out   = head.pixel[PIX_W-1 -: CHAN_W];
  assign green_out = head.pixel[2*CHAN_W-1 -: CHAN_W];
  assign blue_out  = head.pixel[CHAN_W-1:0];
  assign row_end   = head.row_end;
  assign frame_end = head.frame_end;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QDEPTH)
    else $error("result queue overfilled");

  a_stage_has_room: assert property (@(posedge clk) disable iff (rst)
    stg_valid |-> 32'(count) < QDEPTH)
    else $error("staged result has no queue slot");

  a_frame_end_ends_row: assert property (@(posedge clk) disable iff (rst)
    stg_valid && stg_fend |-> stg_rend)
    else $error("frame end without row end");

endmodule

### src/pixel_replicate_upscaler.sv
// Channel  Direction  Handshake             Payload
// in       request    in_valid / in_ready   req_type, blue_in, green_in, red_in
// out      result     out_valid / out_ready status, blue_out, green_out, red_out,
//                                           row_end, frame_end
// cfg      write      cfg_we                cfg_index, cfg_data
//
// One request is taken every clock while in_ready is high; its result is held
// in the read stage beside the registered read of the line buffer, then
// written to the queue, from whose head it is offered.
// A four-entry result queue absorbs output stalls; in_ready drops only when
// the queue and the read stage together hold four results.
// Reset is synchronous and clears all counters and the queue; the line buffer
// is not cleared and needs no clearing pass.
module pixel_replicate_upscaler #(
  parameter int MAX_ROW_PIXELS = upsc_pkg::ROW_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [upsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [upsc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [upsc_pkg::CHAN_W-1:0]    blue_in,
  input  logic [upsc_pkg::CHAN_W-1:0]    green_in,
  input  logic [upsc_pkg::CHAN_W-1:0]    red_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [upsc_pkg::STATUS_W-1:0]  status,
  output logic [upsc_pkg::CHAN_W-1:0]    blue_out,
  output logic [upsc_pkg::CHAN_W-1:0]    green_out,
  output logic [upsc_pkg::CHAN_W-1:0]    red_out,
  output logic                           row_end,
  output logic                           frame_end
);

  import upsc_pkg::*;

  localparam int ADDR_W = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;

  desc_t             desc;
  logic              space;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PIX_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;

  // Front end: takes requests, keeps the counters, drives the line buffer.
  upsc_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS),
    .ADDR_W        (ADDR_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .blue_in  (blue_in),
    .green_in (green_in),
    .red_in   (red_in),
    .space    (space),
    .desc     (desc),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr)
  );

  // Line buffer holding one source row.
  upsc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_ROW_PIXELS),
    .ADDR_W(ADDR_W)
  ) u_row_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Back end: joins read data to each request and queues the results.
  upsc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .desc     (desc),
    .ram_rdata(ram_rdata),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .blue_out (blue_out),
    .green_out(green_out),
    .red_out  (red_out),
    .row_end  (row_end),
    .frame_end(frame_end)
  );

endmodule
